/* hw/rtl/pnc_pkg.sv */
// shared types and constants for the pad nearest channel mapper
package pnc_pkg;

    localparam int PADS     = 1024;
    localparam int SLABS    = 32;
    localparam int CHIPS    = 16;
    localparam int CHANNELS = 64;

    localparam int PAD_AW   = $clog2(PADS);
    localparam int CNT_W    = $clog2(PADS + 1);
    localparam int SLAB_W   = $clog2(SLABS);
    localparam int CHIP_W   = $clog2(CHIPS);
    localparam int CHAN_W   = $clog2(CHANNELS);
    localparam int MASK_DEPTH = SLABS * CHIPS * CHANNELS;
    localparam int MASK_AW  = $clog2(MASK_DEPTH);

    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 48;

    typedef enum logic [1:0] {
        CMD_HIT      = 2'd0,
        CMD_LOAD_DEF = 2'd1,
        CMD_LOAD_OVR = 2'd2,
        CMD_CALIB    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_TOLERANCE = 2'd0,
        REG_MAX_MIP   = 2'd1,
        REG_OVR_SLAB  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [3:0]  chip;
        logic [5:0]  channel;
        logic [15:0] y;
        logic [15:0] x;
    } pad_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_DX    = 7'b0000100,
        ST_DY    = 7'b0001000,
        ST_CMP   = 7'b0010000,
        ST_MASK  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

endpackage

/* hw/rtl/pad_nearest_channel_mapper_top.sv */
// top level of the pad nearest channel mapper
// Each transaction carries one command and gives one result. After reset the
// calibration mask memory is cleared one bit per cycle, so s_tready stays low
// until all 32768 of its bits are clear. Pad loads and calibration rows pass
// through the read and mask states before their result shows. A hit scans the
// selected pad table one entry at a time through a single 17x17 squaring
// multiplier used for x and then y; each entry passes through the read, x, y
// and compare states, and the mask state follows the last entry. The shared
// multiplier and the single pad memory read port set this order of steps. The
// block takes no new transaction until its result is taken.
module pad_nearest_channel_mapper_top
    import pnc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // cell_id[38:0], pos_x[54:39], pos_y[70:55], chip_in[74:71],
    // channel_in[80:75], layer_in[88:81], mpv[104:89], mpv_nan[105], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // new_cell_id[39:0], masked[40], unmapped[41], status[42], zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    logic [15:0] tol_reg, max_mip_reg;
    logic [7:0]  ovr_slab_reg;

    state_t state_reg, state_next;
    logic [1:0]  cmd_reg;
    logic [38:0] cid_reg;
    logic [15:0] hx_reg, hy_reg;
    logic [3:0]  chip_in_reg;
    logic [5:0]  chan_in_reg;
    logic [7:0]  layer_reg;
    logic [15:0] mpv_reg;
    logic        nan_reg;

    logic [CNT_W-1:0] def_cnt_reg, ovr_cnt_reg;
    logic [CNT_W-1:0] idx_reg, n_reg;
    logic             use_ovr_reg;

    pad_t def_mem [PADS];
    pad_t ovr_mem [PADS];
    pad_t def_rd_reg, ovr_rd_reg;
    logic mask_mem [MASK_DEPTH];
    logic mask_rd_reg;

    logic [MASK_AW:0] clr_reg;
    logic             clr_busy;

    logic [33:0] sq_reg, acc_reg, best_reg;
    logic        found_reg;
    logic [3:0]  best_chip_reg;
    logic [5:0]  best_chan_reg;
    logic [31:0] tol2_reg;
    logic        mask_ok;
    logic [M_DATA_W-1:0] out_reg;

    pad_t        cur;
    logic [16:0] diff;
    logic [16:0] mag;
    logic [33:0] sq;
    logic [33:0] d2;
    logic        wr_mask;
    logic [MASK_AW-1:0] wr_addr, rd_addr;
    logic        unmapped, masked;

    assign clr_busy  = !clr_reg[MASK_AW];
    assign s_tready  = (state_reg == ST_IDLE) && !clr_busy;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = out_reg;

    assign cur = use_ovr_reg ? ovr_rd_reg : def_rd_reg;

    always_comb begin
        if (state_reg == ST_DX) begin
            diff = {cur.x[15], cur.x} - {hx_reg[15], hx_reg};
        end else begin
            diff = {cur.y[15], cur.y} - {hy_reg[15], hy_reg};
        end
        mag = diff[16] ? (~diff + 17'd1) : diff;
    end

    assign sq = mag * mag;
    assign d2 = acc_reg + sq_reg;
    assign rd_addr = {cid_reg[8 +: SLAB_W], best_chip_reg[CHIP_W-1:0],
                      best_chan_reg[CHAN_W-1:0]};
    assign wr_addr = {layer_reg[SLAB_W-1:0], chip_in_reg[CHIP_W-1:0],
                      chan_in_reg[CHAN_W-1:0]};
    assign wr_mask = (state_reg == ST_READ) && (cmd_reg == CMD_CALIB)
                     && (layer_reg < 8'(SLABS))
                     && (mpv_reg == 16'd0 || nan_reg || mpv_reg > max_mip_reg);

    assign mask_ok  = cid_reg[15:8] < 8'(SLABS);
    assign unmapped = !found_reg || (best_reg > {2'b00, tol2_reg});
    assign masked   = unmapped || (mask_ok && mask_rd_reg);

    // pad memories
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready && s_tuser == CMD_LOAD_DEF
            && def_cnt_reg < CNT_W'(PADS)) begin
            def_mem[def_cnt_reg[PAD_AW-1:0]] <= {s_tdata[74:71], s_tdata[80:75],
                                                 s_tdata[70:55], s_tdata[54:39]};
        end
        if (s_tvalid && s_tready && s_tuser == CMD_LOAD_OVR
            && ovr_cnt_reg < CNT_W'(PADS)) begin
            ovr_mem[ovr_cnt_reg[PAD_AW-1:0]] <= {s_tdata[74:71], s_tdata[80:75],
                                                 s_tdata[70:55], s_tdata[54:39]};
        end
        def_rd_reg <= def_mem[idx_reg[PAD_AW-1:0]];
        ovr_rd_reg <= ovr_mem[idx_reg[PAD_AW-1:0]];
    end

    // mask bits cleared one per cycle after reset, then set by calibration rows
    always_ff @(posedge aclk) begin
        if (clr_busy) begin
            mask_mem[clr_reg[MASK_AW-1:0]] <= 1'b0;
        end else if (wr_mask) begin
            mask_mem[wr_addr] <= 1'b1;
        end
        mask_rd_reg <= mask_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (clr_busy) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid && !clr_busy) state_next = ST_READ;
            ST_READ: begin
                if (cmd_reg != CMD_HIT || idx_reg >= n_reg) state_next = ST_MASK;
                else state_next = ST_DX;
            end
            ST_DX:   state_next = ST_DY;
            ST_DY:   state_next = ST_CMP;
            ST_CMP:  state_next = ST_READ;
            ST_MASK: state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tol_reg      <= 16'd512;
            max_mip_reg  <= 16'd1600;
            ovr_slab_reg <= 8'd12;
            def_cnt_reg  <= '0;
            ovr_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TOLERANCE: tol_reg      <= cfg_data;
                    REG_MAX_MIP:   max_mip_reg  <= cfg_data;
                    REG_OVR_SLAB:  ovr_slab_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && s_tvalid && !clr_busy) begin
                if (s_tuser == CMD_LOAD_DEF && def_cnt_reg < CNT_W'(PADS))
                    def_cnt_reg <= def_cnt_reg + 1'b1;
                if (s_tuser == CMD_LOAD_OVR && ovr_cnt_reg < CNT_W'(PADS))
                    ovr_cnt_reg <= ovr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cmd_reg     <= s_tuser;
                cid_reg     <= s_tdata[38:0];
                hx_reg      <= s_tdata[54:39];
                hy_reg      <= s_tdata[70:55];
                chip_in_reg <= s_tdata[74:71];
                chan_in_reg <= s_tdata[80:75];
                layer_reg   <= s_tdata[88:81];
                mpv_reg     <= s_tdata[104:89];
                nan_reg     <= s_tdata[105];
                idx_reg     <= '0;
                found_reg   <= 1'b0;
                best_reg    <= '0;
                best_chip_reg <= '0;
                best_chan_reg <= '0;
                tol2_reg    <= tol_reg * tol_reg;
                if (ovr_cnt_reg != '0 && s_tdata[15:8] == ovr_slab_reg) begin
                    use_ovr_reg <= 1'b1;
                    n_reg       <= ovr_cnt_reg;
                end else begin
                    use_ovr_reg <= 1'b0;
                    n_reg       <= def_cnt_reg;
                end
                if (s_tuser == CMD_LOAD_DEF) begin
                    out_reg <= {5'd0, (def_cnt_reg >= CNT_W'(PADS)), 42'd0};
                end else if (s_tuser == CMD_LOAD_OVR) begin
                    out_reg <= {5'd0, (ovr_cnt_reg >= CNT_W'(PADS)), 42'd0};
                end else begin
                    out_reg <= {5'd0, (s_tdata[88:81] >= 8'(SLABS)), 42'd0};
                end
            end
            ST_READ: ;
            ST_DX: begin
                sq_reg  <= sq;
                acc_reg <= '0;
            end
            ST_DY: begin
                acc_reg <= sq_reg;
                sq_reg  <= sq;
            end
            ST_CMP: begin
                if (!found_reg || d2 < best_reg) begin
                    found_reg     <= 1'b1;
                    best_reg      <= d2;
                    best_chip_reg <= cur.chip;
                    best_chan_reg <= cur.channel;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            ST_MASK: begin
                if (cmd_reg == CMD_HIT) begin
                    out_reg <= {5'd0, 1'b0, unmapped, masked,
                                unmapped ? {24'd0, cid_reg[15:0]}
                                         : {2'b00, best_chan_reg, 12'd0, best_chip_reg,
                                            cid_reg[15:0]}};
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

endmodule

/* tb/sv/pnc_checker.sv */
// checker for the pad nearest channel mapper: predicts each result and compares it
`timescale 1ns / 100ps
module pnc_checker
    import pnc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic        status;
        logic        unmapped;
        logic        masked;
        logic [39:0] new_cid;
    } mapping_t;

    logic [15:0] tol_q;
    logic [15:0] mip_q;
    logic [7:0]  ovr_slab_q;
    pad_t        def_tab [PADS];
    pad_t        ovr_tab [PADS];
    int          def_n;
    int          ovr_n;
    bit          mask_mem [MASK_DEPTH];
    mapping_t    expected_q [$];

    function automatic longint unsigned sq(logic signed [15:0] a, logic signed [15:0] b);
        longint signed d;
        d = longint'(a) - longint'(b);
        return longint'(d * d);
    endfunction

    function automatic mapping_t map_item(logic [1:0] cmd, logic [S_DATA_W-1:0] d);
        mapping_t r;
        logic [7:0]  sys, slab, lay;
        logic signed [15:0] hx, hy;
        logic [3:0]  chip;
        logic [5:0]  chan;
        logic [15:0] mpv;
        longint unsigned best, d2, tol2;
        bit          found;
        pad_t        p, bp;
        int          n;
        bit          use_ovr;
        r = '0;
        hx = d[54:39];
        hy = d[70:55];
        chip = d[74:71];
        chan = d[80:75];
        lay = d[88:81];
        mpv = d[104:89];
        case (cmd)
            CMD_LOAD_DEF: begin
                if (def_n >= PADS) r.status = 1'b1;
                else begin
                    def_tab[def_n] = {chip, chan, hy, hx};
                    def_n++;
                end
            end
            CMD_LOAD_OVR: begin
                if (ovr_n >= PADS) r.status = 1'b1;
                else begin
                    ovr_tab[ovr_n] = {chip, chan, hy, hx};
                    ovr_n++;
                end
            end
            CMD_CALIB: begin
                if (lay >= SLABS || chip >= CHIPS || chan >= CHANNELS) r.status = 1'b1;
                else if (mpv == 0 || d[105] || mpv > mip_q)
                    mask_mem[(int'(lay) * CHIPS + chip) * CHANNELS + chan] = 1'b1;
            end
            default: begin
                sys = d[7:0];
                slab = d[15:8];
                use_ovr = ovr_n != 0 && slab == ovr_slab_q;
                n = use_ovr ? ovr_n : def_n;
                found = 0;
                best = 0;
                bp = '0;
                for (int i = 0; i < n; i++) begin
                    p = use_ovr ? ovr_tab[i] : def_tab[i];
                    d2 = sq(p.x, hx) + sq(p.y, hy);
                    if (!found || d2 < best) begin
                        found = 1;
                        best = d2;
                        bp = p;
                    end
                end
                tol2 = longint'(tol_q) * longint'(tol_q);
                r.unmapped = !found || best > tol2;
                r.new_cid = {24'd0, slab, sys};
                if (!r.unmapped) begin
                    r.new_cid[31:16] = 16'(bp.chip);
                    r.new_cid[39:32] = 8'(bp.channel);
                end
                r.masked = r.unmapped;
                if (!r.masked && slab < SLABS)
                    r.masked = mask_mem[(int'(slab) * CHIPS + bp.chip) * CHANNELS + bp.channel];
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        mapping_t e, a;
        int errs;
        errs = 0;
        if (!aresetn) begin
            tol_q <= 16'd512;
            mip_q <= 16'd1600;
            ovr_slab_q <= 8'd12;
            def_n = 0;
            ovr_n = 0;
            foreach (mask_mem[i]) mask_mem[i] = 1'b0;
            expected_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_TOLERANCE: tol_q <= cfg_data;
                    REG_MAX_MIP:   mip_q <= cfg_data;
                    REG_OVR_SLAB:  ovr_slab_q <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expected_q = {expected_q, map_item(s_tuser, s_tdata)};
            if (m_tvalid && m_tready) begin
                a = m_tdata[42:0];
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction %h", m_tdata);
                    errs++;
                end else begin
                    e = expected_q.pop_front();
                    if (a.new_cid !== e.new_cid) begin
                        $error("new_cell_id expected %h actual %h", e.new_cid, a.new_cid);
                        errs++;
                    end
                    if (a.masked !== e.masked) begin
                        $error("masked expected %0d actual %0d", e.masked, a.masked);
                        errs++;
                    end
                    if (a.unmapped !== e.unmapped) begin
                        $error("unmapped expected %0d actual %0d", e.unmapped, a.unmapped);
                        errs++;
                    end
                    if (a.status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, a.status);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        pending <= expected_q.size();
    end

endmodule

/* tb/sv/tb_top.sv */
// testbench top for the pad nearest channel mapper: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module tb_top;
    import pnc_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [15:0]         cfg_data;
    int                  fail_count;
    int                  pending;
    int                  idle_cycles;
    bit                  calm;
    bit                  hold_sink;
    int                  slab_pick;

    pad_nearest_channel_mapper_top dut (.*);

    pnc_checker chk (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_tready <= 0;
                repeat (3000) @(posedge aclk);
                hold_sink = 0;
            end
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(input cmd_t cmd, input logic [38:0] cid, input logic [15:0] x,
                        input logic [15:0] y, input logic [3:0] chip, input logic [5:0] chan,
                        input logic [7:0] lay, input logic [15:0] mpv, input logic nan);
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {6'd0, nan, mpv, lay, chan, chip, y, x, cid};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic hit(input logic [7:0] slab, input logic [15:0] x, input logic [15:0] y);
        send(CMD_HIT, 39'({$urandom, $urandom}) & 39'h7f_ffff_00ff | (39'(slab) << 8),
             x, y, 4'($urandom), 6'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic near_hit(input logic [7:0] slab);
        hit(slab, 16'($urandom_range(0, 2047)) - 16'd1024, 16'($urandom_range(0, 2047)) - 16'd1024);
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = CMD_HIT;
        cfg_valid = 0;
        cfg_index = REG_TOLERANCE;
        cfg_data = '0;
        calm = 0;
        hold_sink = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // empty tables
        hit(8'd3, 16'h0000, 16'h0000);
        hit(8'd12, 16'h8000, 16'h7fff);
        // pads at the coordinate extremes and a tie
        send(CMD_LOAD_DEF, '0, 16'h8000, 16'h8000, 4'd15, 6'd63, '0, '0, 1'b0);
        send(CMD_LOAD_DEF, '0, 16'h7fff, 16'h7fff, 4'd1, 6'd2, '0, '0, 1'b0);
        send(CMD_LOAD_DEF, '0, 16'd100, 16'd0, 4'd3, 6'd4, '0, '0, 1'b0);
        send(CMD_LOAD_DEF, '0, 16'hff9c, 16'd0, 4'd5, 6'd6, '0, '0, 1'b0);
        send(CMD_LOAD_OVR, '0, 16'd0, 16'd0, 4'd7, 6'd8, '0, '0, 1'b0);
        // calibration: zero, nan, high, in range, out of range
        send(CMD_CALIB, '0, '0, '0, 4'd3, 6'd4, 8'd0, 16'd0, 1'b0);
        send(CMD_CALIB, '0, '0, '0, 4'd5, 6'd6, 8'd31, 16'd100, 1'b1);
        send(CMD_CALIB, '0, '0, '0, 4'd7, 6'd8, 8'd12, 16'd1601, 1'b0);
        send(CMD_CALIB, '0, '0, '0, 4'd1, 6'd2, 8'd0, 16'd1600, 1'b0);
        send(CMD_CALIB, '0, '0, '0, 4'd1, 6'd2, 8'd32, 16'd0, 1'b0);
        send(CMD_CALIB, '0, '0, '0, 4'd1, 6'd2, 8'd255, 16'hffff, 1'b1);
        hit(8'd0, 16'd0, 16'd0);
        hit(8'd31, 16'd0, 16'd0);
        hit(8'd12, 16'd10, 16'd10);
        hit(8'd255, 16'h8000, 16'h8000);
        hit(8'd0, 16'h7fff, 16'h7fff);
        hit(8'd0, 16'd1000, 16'd1000);
        drain();
        write_reg(REG_TOLERANCE, 16'd0);
        write_reg(REG_MAX_MIP, 16'd0);
        write_reg(REG_OVR_SLAB, 16'd255);
        hit(8'd255, 16'd0, 16'd0);
        hit(8'd0, 16'd100, 16'd0);
        hit(8'd0, 16'd101, 16'd0);
        send(CMD_CALIB, '0, '0, '0, 4'd0, 6'd0, 8'd1, 16'd1, 1'b0);
        write_reg(REG_TOLERANCE, 16'hffff);
        hit(8'd1, 16'h7fff, 16'h8000);
        hit(8'd12, 16'h8000, 16'h7fff);

        // load the override table with small positions
        for (int i = 0; i < 200; i++) begin
            calm = (i >= 60 && i < 140);
            send(CMD_LOAD_OVR, '0, 16'($urandom_range(0, 4095)) - 16'd2048,
                 16'($urandom_range(0, 4095)) - 16'd2048, 4'($urandom), 6'($urandom),
                 '0, '0, 1'b0);
        end
        calm = 0;
        write_reg(REG_TOLERANCE, 16'd512);
        write_reg(REG_MAX_MIP, 16'd1600);
        write_reg(REG_OVR_SLAB, 16'd12);

        for (int i = 0; i < 350; i++) begin
            calm = (i >= 120 && i < 180);
            if (i == 60) hold_sink = 1;
            if (i == 240) drain();
            slab_pick = $urandom_range(0, 9) < 3 ? 12 : $urandom_range(0, 40);
            case ($urandom_range(0, 9))
                0, 1: send(CMD_LOAD_DEF, '0, 16'($urandom_range(0, 4095)) - 16'd2048,
                           $urandom_range(0, 1) ? 16'($urandom) :
                           16'($urandom_range(0, 4095)) - 16'd2048,
                           4'($urandom), 6'($urandom), '0, '0, 1'b0);
                2, 3: send(CMD_CALIB, '0, '0, '0, 4'($urandom), 6'($urandom),
                           $urandom_range(0, 9) ? 8'($urandom_range(0, 31)) : 8'($urandom),
                           $urandom_range(0, 3) ? 16'($urandom_range(0, 3200)) : 16'($urandom),
                           $urandom_range(0, 7) == 0);
                4: hit(8'($urandom), 16'($urandom), 16'($urandom));
                default: near_hit(8'(slab_pick));
            endcase
        end
        calm = 0;
        drain();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pnc_pkg.sv
hw/rtl/pad_nearest_channel_mapper_top.sv
tb/sv/pnc_checker.sv
tb/sv/tb_top.sv
